// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define GCED_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle implication.
`define GCED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/gced_pkg.sv =====
// Shared types and constants of the gamepad change event detector.
package gced_pkg;

    localparam int PADS_DEF    = 16;
    localparam int BUTTONS_DEF = 15;
    localparam int AXES_DEF    = 6;

    localparam int PAD_W       = 4;
    localparam int MASK_W      = 15;
    localparam int AXIS_W      = 16;
    localparam int AXIS_FIELDS = 6;
    localparam int STICK_AXES  = 4;
    localparam int CFG_W       = 15;
    localparam int CODE_W      = 4;
    localparam int KIND_W      = 3;

    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 32;

    localparam logic [CFG_W-1:0] DEADZONE_RST = 15'd2621;
    localparam logic [CFG_W-1:0] EPSILON_RST  = 15'd328;

    localparam logic CFG_DEADZONE = 1'b0;
    localparam logic CFG_EPSILON  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        EV_CONNECT    = 3'd0,
        EV_DISCONNECT = 3'd1,
        EV_PRESS      = 3'd2,
        EV_RELEASE    = 3'd3,
        EV_AXIS       = 3'd4
    } ev_kind_t;

    typedef struct packed {
        logic [PAD_W-1:0] pad;
        logic             connect;
        logic             mapped;
    } ev_hdr_t;

endpackage

// ===== hw/rtl/gced_track.sv =====
// Per-pad presence and history tracking; computes the pending event set of one sample.
module gced_track #(
    parameter int PADS    = gced_pkg::PADS_DEF,
    parameter int BUTTONS = gced_pkg::BUTTONS_DEF,
    parameter int AXES    = gced_pkg::AXES_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         adv,
    input  logic [gced_pkg::PAD_W-1:0]                   pad_index,
    input  logic                                         present,
    input  logic                                         is_mapped,
    input  logic                                         sample_valid,
    input  logic [gced_pkg::MASK_W-1:0]                  button_mask,
    input  logic [gced_pkg::AXIS_FIELDS-1:0][gced_pkg::AXIS_W-1:0] axis_in,
    input  logic [gced_pkg::CFG_W-1:0]                   deadzone,
    input  logic [gced_pkg::CFG_W-1:0]                   change_epsilon,
    output logic [BUTTONS+AXES:0]                        pend,
    output gced_pkg::ev_hdr_t                            hdr,
    output logic [BUTTONS-1:0]                           btn_new,
    output logic [AXES-1:0][gced_pkg::AXIS_W-1:0]        ax_new
);
    import gced_pkg::*;

    localparam int PAD_IW = (PADS > 1) ? $clog2(PADS) : 1;
    localparam int BTN_N  = (BUTTONS > MASK_W) ? BUTTONS : MASK_W;
    localparam int AX_N   = (AXES > AXIS_FIELDS) ? AXES : AXIS_FIELDS;
    localparam logic [PAD_W:0] PAD_LIM = (PAD_W+1)'(PADS);

    logic [PADS-1:0]                present_reg;
    logic [PADS-1:0]                hist_reg;
    logic [BUTTONS-1:0]             btn_hist_reg [PADS];
    logic [AXES-1:0][AXIS_W-1:0]    ax_hist_reg  [PADS];

    logic [PAD_IW-1:0]              pad_sel;
    logic                           pad_ok;
    logic                           pres_chg;
    logic                           do_cmp;
    logic                           hist;
    logic [BTN_N-1:0]               btn_src;
    logic [AX_N-1:0][AXIS_W-1:0]    ax_src;
    logic [BUTTONS-1:0]             btn_chg;
    logic [AXES-1:0]                ax_chg;

    assign pad_sel  = pad_index[PAD_IW-1:0];
    assign pad_ok   = {1'b0, pad_index} < PAD_LIM;
    assign pres_chg = pad_ok && (present != present_reg[pad_sel]);
    assign do_cmp   = pad_ok && !pres_chg && present && is_mapped && sample_valid;
    assign hist     = do_cmp && hist_reg[pad_sel];
    assign btn_src  = BTN_N'(button_mask);
    assign ax_src   = (AX_N*AXIS_W)'(axis_in);
    assign btn_new  = btn_src[BUTTONS-1:0];
    assign btn_chg  = hist ? (btn_new ^ btn_hist_reg[pad_sel]) : '0;

    always_comb
    begin
        logic signed [AXIS_W:0] v;
        logic signed [AXIS_W:0] h;
        logic signed [AXIS_W:0] d;
        logic [AXIS_W:0]        mag;
        logic [AXIS_W:0]        dmag;
        for (int a = 0; a < AXES; a++)
        begin
            v   = (AXIS_W+1)'(signed'(ax_src[a]));
            mag = v[AXIS_W] ? unsigned'(-v) : unsigned'(v);
            if (a < STICK_AXES && mag < {2'b00, deadzone})
                v = '0;
            ax_new[a] = v[AXIS_W-1:0];
            h    = (AXIS_W+1)'(signed'(ax_hist_reg[pad_sel][a]));
            d    = v - h;
            dmag = d[AXIS_W] ? unsigned'(-d) : unsigned'(d);
            ax_chg[a] = hist && (dmag > {2'b00, change_epsilon});
        end
    end

    assign pend        = {ax_chg, btn_chg, pres_chg};
    assign hdr.pad     = pad_index;
    assign hdr.connect = present;
    assign hdr.mapped  = is_mapped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            hist_reg    <= '0;
        end
        else if (adv)
        begin
            if (pres_chg)
            begin
                present_reg[pad_sel] <= present;
                hist_reg[pad_sel]    <= 1'b0;
            end
            else if (do_cmp)
            begin
                hist_reg[pad_sel] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && do_cmp)
        begin
            btn_hist_reg[pad_sel] <= btn_new;
            ax_hist_reg[pad_sel]  <= ax_new;
        end
    end

endmodule

// ===== hw/rtl/gced_emit.sv =====
// Event serializer: pending event set, lowest-first selection and output register.
`include "assert_macros.svh"

module gced_emit #(
    parameter int BUTTONS = gced_pkg::BUTTONS_DEF,
    parameter int AXES    = gced_pkg::AXES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  load,
    input  logic [BUTTONS+AXES:0]                 pend_in,
    input  gced_pkg::ev_hdr_t                     hdr_in,
    input  logic [BUTTONS-1:0]                    btn_in,
    input  logic [AXES-1:0][gced_pkg::AXIS_W-1:0] ax_in,
    output logic                                  free,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [gced_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // pad[3:0] code[7:4] mapped[8] value[24:9]
    output logic [gced_pkg::KIND_W-1:0]           m_axis_tuser,  // event_kind[2:0]
    output logic                                  m_axis_tlast
);
    import gced_pkg::*;

    localparam int EV_W = BUTTONS + AXES + 1;

    logic [EV_W-1:0]               pend_reg;
    ev_hdr_t                       hdr_reg;
    logic [BUTTONS-1:0]            btn_reg;
    logic [AXES-1:0][AXIS_W-1:0]   ax_reg;

    logic                          out_valid_reg;
    ev_kind_t                      out_kind_reg;
    logic [PAD_W-1:0]              out_pad_reg;
    logic [CODE_W-1:0]             out_code_reg;
    logic                          out_mapped_reg;
    logic [AXIS_W-1:0]             out_value_reg;
    logic                          out_last_reg;

    logic [EV_W-1:0]               oh;
    logic [EV_W-1:0]               rem;
    logic                          pend_any;
    logic                          fire;
    logic                          is_btn;
    logic                          btn_dir;
    logic [CODE_W-1:0]             code;
    logic [AXIS_W-1:0]             value;
    ev_kind_t                      kind;

    assign pend_any = |pend_reg;
    assign oh       = pend_reg & (~pend_reg + EV_W'(1));
    assign rem      = pend_reg & ~oh;
    assign fire     = pend_any && (!out_valid_reg || m_axis_tready);
    assign free     = !pend_any || (fire && rem == '0);
    assign is_btn   = |oh[BUTTONS:1];
    assign btn_dir  = |(oh[BUTTONS:1] & btn_reg);

    always_comb
    begin
        code  = '0;
        value = '0;
        for (int i = 0; i < BUTTONS; i++)
        begin
            if (oh[1+i])
                code = code | CODE_W'(i);
        end
        for (int a = 0; a < AXES; a++)
        begin
            if (oh[1+BUTTONS+a])
            begin
                code  = code | CODE_W'(a);
                value = value | ax_reg[a];
            end
        end
    end

    always_comb
    begin
        priority if (oh[0])
            kind = hdr_reg.connect ? EV_CONNECT : EV_DISCONNECT;
        else if (is_btn)
            kind = btn_dir ? EV_PRESS : EV_RELEASE;
        else
            kind = EV_AXIS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                pend_reg <= pend_in;
            else if (fire)
                pend_reg <= rem;

            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hdr_reg <= hdr_in;
            btn_reg <= btn_in;
            ax_reg  <= ax_in;
        end
        if (fire)
        begin
            out_kind_reg   <= kind;
            out_pad_reg    <= hdr_reg.pad;
            out_code_reg   <= code;
            out_mapped_reg <= oh[0] && hdr_reg.connect && hdr_reg.mapped;
            out_value_reg  <= value;
            out_last_reg   <= (rem == '0);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_value_reg, out_mapped_reg, out_code_reg,
                                         out_pad_reg});

    `GCED_ASSERT(a_no_overwrite, (out_valid_reg && !m_axis_tready) |-> !fire, "output overwritten while stalled")
    `GCED_ASSERT(a_presence_alone, pend_reg[0] |-> (pend_reg[EV_W-1:1] == '0), "presence event mixed with others")
    `GCED_ASSERT(a_disc_unmapped, (out_valid_reg && out_kind_reg == EV_DISCONNECT) |-> !out_mapped_reg, "disconnect carries mapped flag")

endmodule

// ===== hw/rtl/gamepad_change_event_detector.sv =====
// Top level of the gamepad change event detector.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    one poll sample per transaction
//  m_axis    out  m_axis_tvalid/tready    one event per transaction, tlast on the final one
//  cfg       in   cfg_wr_en               cfg_addr 0 deadzone, 1 change_epsilon
//
// Sample path: input register, compare against the per-pad history, then the event
// serializer and output register. A sample giving several events occupies the serializer
// until its last event fires; samples giving zero or one event stream at one per cycle
// when the output does not stall, and the serializer then emits one event per cycle.
// Reset clears presence and history flags; button and axis history need no clearing.
// Output stalls back up through the serializer into the input register.
`include "assert_macros.svh"

module gamepad_change_event_detector #(
    parameter int PADS    = gced_pkg::PADS_DEF,
    parameter int BUTTONS = gced_pkg::BUTTONS_DEF,
    parameter int AXES    = gced_pkg::AXES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // pad_index[3:0] present[4] is_mapped[5] sample_valid[6] button_mask[21:7]
    // axis_0[37:22] axis_1[53:38] axis_2[69:54] axis_3[85:70] axis_4[101:86] axis_5[117:102]
    input  logic [gced_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // event_pad[3:0] event_code[7:4] event_mapped[8] event_axis_value[24:9]
    output logic [gced_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // event_kind[2:0]
    output logic [gced_pkg::KIND_W-1:0]         m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_addr,
    input  logic [gced_pkg::CFG_W-1:0]          cfg_wr_data
);
    import gced_pkg::*;

    localparam int POS_PRESENT = PAD_W;
    localparam int POS_MAPPED  = PAD_W + 1;
    localparam int POS_VALID   = PAD_W + 2;
    localparam int POS_MASK    = PAD_W + 3;
    localparam int POS_AXES    = POS_MASK + MASK_W;

    logic                                   in_valid_reg;
    logic [IN_TDATA_W-1:0]                  in_data_reg;
    logic [CFG_W-1:0]                       deadzone_reg;
    logic [CFG_W-1:0]                       epsilon_reg;

    logic                                   adv;
    logic                                   free;
    logic [AXIS_FIELDS-1:0][AXIS_W-1:0]     axis_in;
    logic [BUTTONS+AXES:0]                  pend;
    ev_hdr_t                                hdr;
    logic [BUTTONS-1:0]                     btn_new;
    logic [AXES-1:0][AXIS_W-1:0]            ax_new;

    assign adv           = in_valid_reg && free;
    assign s_axis_tready = !in_valid_reg || free;
    assign axis_in       = in_data_reg[POS_AXES +: AXIS_FIELDS*AXIS_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            deadzone_reg <= DEADZONE_RST;
            epsilon_reg  <= EPSILON_RST;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    CFG_DEADZONE: deadzone_reg <= cfg_wr_data;
                    CFG_EPSILON:  epsilon_reg  <= cfg_wr_data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_data_reg <= s_axis_tdata;
    end

    gced_track #(
        .PADS    (PADS),
        .BUTTONS (BUTTONS),
        .AXES    (AXES)
    ) u_track (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .pad_index      (in_data_reg[PAD_W-1:0]),
        .present        (in_data_reg[POS_PRESENT]),
        .is_mapped      (in_data_reg[POS_MAPPED]),
        .sample_valid   (in_data_reg[POS_VALID]),
        .button_mask    (in_data_reg[POS_MASK +: MASK_W]),
        .axis_in        (axis_in),
        .deadzone       (deadzone_reg),
        .change_epsilon (epsilon_reg),
        .pend           (pend),
        .hdr            (hdr),
        .btn_new        (btn_new),
        .ax_new         (ax_new)
    );

    gced_emit #(
        .BUTTONS (BUTTONS),
        .AXES    (AXES)
    ) u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (adv),
        .pend_in       (pend),
        .hdr_in        (hdr),
        .btn_in        (btn_new),
        .ax_in         (ax_new),
        .free          (free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    `GCED_ASSERT_NEXT(a_drain_empty, adv && !s_axis_tvalid, !in_valid_reg, "input register kept a drained sample")

endmodule
